### design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the thread scheduler
// Field widths, operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int unsigned THREAD_COUNT_DEF = 4;
  localparam int unsigned MUTEX_COUNT_DEF  = 4;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned MIDX_W  = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned ARG_W   = 16;
  localparam int unsigned RUN_W   = 3;
  localparam int unsigned CRT_W   = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SPAWN  = 3'd0,
    OP_YIELD  = 3'd1,
    OP_LOCK   = 3'd2,
    OP_UNLOCK = 3'd3,
    OP_EXIT   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NO_READY  = 2'd2,
    ST_EXIT_INIT = 2'd3
  } status_e;

  typedef struct packed {
    logic [RUN_W-1:0]         running_thread;
    logic [CRT_W-1:0]         created_thread;
    logic                     fresh_start;
    logic [ADDR_W-1:0]        start_address;
    logic signed [ARG_W-1:0]  start_argument;
    status_e                  status;
  } result_t;

endpackage

### design/tsm_if.sv
// ----------------------------------------------------------------------------
// tsm_if: event and result channels of the thread scheduler
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tsm_event_if
  import tsm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [MIDX_W-1:0]       mutex_index;
  logic [ADDR_W-1:0]       entry_address;
  logic signed [ARG_W-1:0] start_value;

  modport source (output valid, opcode, mutex_index, entry_address, start_value,
                  input ready);
  modport sink   (input valid, opcode, mutex_index, entry_address, start_value,
                  output ready);
endinterface

interface tsm_result_if
  import tsm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [RUN_W-1:0]        running_thread;
  logic [CRT_W-1:0]        created_thread;
  logic                    fresh_start;
  logic [ADDR_W-1:0]       start_address;
  logic signed [ARG_W-1:0] start_argument;
  logic [STAT_W-1:0]       status;

  modport source (output valid, running_thread, created_thread, fresh_start,
                         start_address, start_argument, status,
                  input ready);
  modport sink   (input valid, running_thread, created_thread, fresh_start,
                        start_address, start_argument, status,
                  output ready);
endinterface

### design/tsm_sched.sv
// ----------------------------------------------------------------------------
// tsm_sched: queue state and event logic
// Holds the linked free, ready and wait queues, the running slot, the mutex
// flags and the per-slot entry and argument stores. One event per transfer.
// ----------------------------------------------------------------------------
module tsm_sched
  import tsm_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF,
  parameter int unsigned MUTEX_COUNT  = MUTEX_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [MIDX_W-1:0]       mutex_index_i,
  input  logic [ADDR_W-1:0]       entry_address_i,
  input  logic signed [ARG_W-1:0] start_value_i,
  output result_t                 result_o
);

  localparam int unsigned SLOTS = THREAD_COUNT + 1;
  localparam int unsigned SW    = $clog2(SLOTS + 1);
  localparam int unsigned LW    = $clog2(SLOTS);
  localparam int unsigned TW    = $clog2(THREAD_COUNT);
  localparam int unsigned MW    = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam logic [SW-1:0] NIL  = SW'(THREAD_COUNT + 1);
  localparam logic [SW-1:0] INIT = SW'(THREAD_COUNT);
  localparam logic [SW-1:0] NSL  = SW'(SLOTS);
  localparam logic [SW-1:0] NTH  = SW'(THREAD_COUNT);

  logic [SW-1:0] link_q [SLOTS];
  logic [SW-1:0] link_d [SLOTS];
  logic [SW-1:0] free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [SW-1:0] ready_head_q, ready_head_d, ready_tail_q, ready_tail_d;
  logic [SW-1:0] running_q, running_d;
  logic [SW-1:0] wait_head_q [MUTEX_COUNT];
  logic [SW-1:0] wait_head_d [MUTEX_COUNT];
  logic [SW-1:0] wait_tail_q [MUTEX_COUNT];
  logic [SW-1:0] wait_tail_d [MUTEX_COUNT];
  logic [MUTEX_COUNT-1:0]  held_q, held_d;
  logic [THREAD_COUNT-1:0] never_run_q, never_run_d;
  logic [ADDR_W-1:0]       entry_q [THREAD_COUNT];
  logic signed [ARG_W-1:0] arg_q [THREAD_COUNT];

  logic          store_we;
  logic [SW-1:0] store_slot;
  logic [4:0]    m_wide;
  logic [MW-1:0] m_idx;
  logic          m_ok;

  assign m_wide = {3'b000, mutex_index_i};
  assign m_idx  = m_wide[MW-1:0];
  assign m_ok   = (m_wide < 5'(MUTEX_COUNT));

  always_comb begin
    logic [SW-1:0] p;
    logic [SW-1:0] r;
    logic [SW-1:0] wh;
    logic [SW-1:0] wt;
    logic          disp;
    link_d       = link_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    ready_head_d = ready_head_q;
    ready_tail_d = ready_tail_q;
    running_d    = running_q;
    wait_head_d  = wait_head_q;
    wait_tail_d  = wait_tail_q;
    held_d       = held_q;
    never_run_d  = never_run_q;
    store_we     = 1'b0;
    store_slot   = free_head_q;
    disp         = 1'b0;
    p            = NIL;
    r            = running_q;
    wh           = wait_head_q[m_idx];
    wt           = wait_tail_q[m_idx];
    result_o                = '0;
    result_o.status         = ST_OK;

    case (op_e'(opcode_i))
      OP_SPAWN: begin
        if (free_head_q >= NTH) begin
          result_o.status = ST_NO_FREE;
        end else begin
          p = free_head_q;
          free_head_d = link_q[p[LW-1:0]];
          if (free_head_d >= NSL) begin
            free_head_d = NIL;
            free_tail_d = NIL;
          end
          store_we = 1'b1;
          never_run_d[p[TW-1:0]] = 1'b1;
          link_d[p[LW-1:0]] = NIL;
          if (ready_head_q >= NSL) begin
            ready_head_d = p;
          end else if (ready_tail_q < NSL) begin
            link_d[ready_tail_q[LW-1:0]] = p;
          end
          ready_tail_d = p;
          result_o.created_thread = CRT_W'(p);
        end
      end
      OP_YIELD: begin
        link_d[r[LW-1:0]] = NIL;
        if (ready_head_d >= NSL) begin
          ready_head_d = r;
        end else if (ready_tail_d < NSL) begin
          link_d[ready_tail_d[LW-1:0]] = r;
        end
        ready_tail_d = r;
        disp = 1'b1;
      end
      OP_LOCK: begin
        if (m_ok) begin
          if (!held_q[m_idx]) begin
            held_d[m_idx] = 1'b1;
          end else if (ready_head_q >= NSL) begin
            result_o.status = ST_NO_READY;
          end else begin
            link_d[r[LW-1:0]] = NIL;
            if (wh >= NSL) begin
              wait_head_d[m_idx] = r;
            end else if (wt < NSL) begin
              link_d[wt[LW-1:0]] = r;
            end
            wait_tail_d[m_idx] = r;
            disp = 1'b1;
          end
        end
      end
      OP_UNLOCK: begin
        if (m_ok) begin
          if (wh < NSL) begin
            link_d[r[LW-1:0]] = NIL;
            if (ready_head_q >= NSL) begin
              ready_head_d = r;
            end else if (ready_tail_q < NSL) begin
              link_d[ready_tail_q[LW-1:0]] = r;
            end
            ready_tail_d = r;
            // The first waiter takes over; the mutex stays held.
            p = wh;
            wait_head_d[m_idx] = link_d[wh[LW-1:0]];
            if (wait_head_d[m_idx] >= NSL) begin
              wait_head_d[m_idx] = NIL;
              wait_tail_d[m_idx] = NIL;
            end
            running_d = p;
          end else begin
            held_d[m_idx] = 1'b0;
          end
        end
      end
      OP_EXIT: begin
        if (running_q >= NTH) begin
          result_o.status = ST_EXIT_INIT;
        end else if (ready_head_q >= NSL) begin
          result_o.status = ST_NO_READY;
        end else begin
          link_d[r[LW-1:0]] = NIL;
          if (free_head_q >= NSL) begin
            free_head_d = r;
          end else if (free_tail_q < NSL) begin
            link_d[free_tail_q[LW-1:0]] = r;
          end
          free_tail_d = r;
          disp = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Pop of the ready queue, shared by yield, contended lock and exit.
    if (disp) begin
      p = ready_head_d;
      ready_head_d = link_d[p[LW-1:0]];
      if (ready_head_d >= NSL) begin
        ready_head_d = NIL;
        ready_tail_d = NIL;
      end
      running_d = p;
    end

    if (running_d != running_q || disp) begin
      if (running_d < NTH && never_run_q[running_d[TW-1:0]]) begin
        never_run_d[running_d[TW-1:0]] = 1'b0;
        result_o.fresh_start    = 1'b1;
        result_o.start_address  = entry_q[running_d[TW-1:0]];
        result_o.start_argument = arg_q[running_d[TW-1:0]];
      end
    end
    result_o.running_thread = RUN_W'(running_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_q[i] <= (i < THREAD_COUNT - 1) ? SW'(i + 1) : NIL;
      end
      free_head_q  <= '0;
      free_tail_q  <= SW'(THREAD_COUNT - 1);
      ready_head_q <= NIL;
      ready_tail_q <= NIL;
      running_q    <= INIT;
      for (int i = 0; i < MUTEX_COUNT; i++) begin
        wait_head_q[i] <= NIL;
        wait_tail_q[i] <= NIL;
      end
      held_q      <= '0;
      never_run_q <= '0;
    end else if (accept_i) begin
      link_q       <= link_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      ready_head_q <= ready_head_d;
      ready_tail_q <= ready_tail_d;
      running_q    <= running_d;
      wait_head_q  <= wait_head_d;
      wait_tail_q  <= wait_tail_d;
      held_q       <= held_d;
      never_run_q  <= never_run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && store_we) begin
      entry_q[store_slot[TW-1:0]] <= entry_address_i;
      arg_q[store_slot[TW-1:0]]   <= start_value_i;
    end
  end

endmodule

### design/tsm_out_reg.sv
// ----------------------------------------------------------------------------
// tsm_out_reg: result register
// Holds one result until the sink takes it; a new event can be taken in the
// same cycle that the held result is transferred.
// ----------------------------------------------------------------------------
module tsm_out_reg
  import tsm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    in_ready_o,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

### design/thread_scheduler_mutex.sv
// ----------------------------------------------------------------------------
// thread_scheduler_mutex: FIFO thread scheduler with mutexes
// Channel   Direction  Payload
// evt_i     in         opcode, mutex_index, entry_address, start_value
// res_o     out        running_thread, created_thread, fresh_start,
//                      start_address, start_argument, status
// The result of each transferred event is valid in the next cycle; one
// event per cycle is sustained while the sink is ready.
// The event channel stalls only while a result waits and the sink is not
// ready. Reset is asynchronous and puts all slots but the initial context
// in the free queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module thread_scheduler_mutex
  import tsm_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF,
  parameter int unsigned MUTEX_COUNT  = MUTEX_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsm_event_if.sink     evt_i,
  tsm_result_if.source  res_o
);

  logic    accept;
  logic    in_ready;
  result_t next_result;
  result_t held_result;

  assign accept      = evt_i.valid && in_ready;
  assign evt_i.ready = in_ready;

  tsm_sched #(
    .THREAD_COUNT (THREAD_COUNT),
    .MUTEX_COUNT  (MUTEX_COUNT)
  ) u_sched (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .opcode_i        (evt_i.opcode),
    .mutex_index_i   (evt_i.mutex_index),
    .entry_address_i (evt_i.entry_address),
    .start_value_i   (evt_i.start_value),
    .result_o        (next_result)
  );

  tsm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (next_result),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .in_ready_o  (in_ready),
    .result_o    (held_result)
  );

  assign res_o.running_thread = held_result.running_thread;
  assign res_o.created_thread = held_result.created_thread;
  assign res_o.fresh_start    = held_result.fresh_start;
  assign res_o.start_address  = held_result.start_address;
  assign res_o.start_argument = held_result.start_argument;
  assign res_o.status         = held_result.status;

endmodule
